>>> sv/dws_pkg.sv
// package for the dfs work stack: operation and status codes, controller states,
// and the command and status structs shared by the controller and the datapath
`default_nettype none
package dws_pkg;
   typedef enum logic [2:0] {
      KIND_PUSH  = 3'd0,
      KIND_POP   = 3'd1,
      KIND_OPEN  = 3'd2,
      KIND_PEEK  = 3'd3,
      KIND_SPLIT = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2,
      ST_NOSPLIT   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TOP_RD,
      S_TOP_WAIT,
      S_CS_START,
      S_CS_WAIT,
      S_FIND_RD,
      S_FIND_CHK,
      S_N_START,
      S_N_WAIT,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_EMIT,
      S_RESULT
   } state_type;

   localparam int VALUE_W = 16;
   localparam int FILL_W  = 7;
   localparam int DIV_W   = 8;

   typedef struct packed {
      logic       load;
      logic       rd_top;
      logic       do_op;
      logic       div_cs;
      logic       cs_load;
      logic       rd_scan;
      logic       find_step;
      logic       fail;
      logic       div_n;
      logic       set_n;
      logic       scan_step;
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       scan_done;
      logic       seg_zero;
      logic       found;
      logic       rem_zero;
      logic       div_busy;
   } sts_type;
endpackage
`default_nettype wire

>>> sv/dws_if.sv
// valid/ready channel interface for the dfs work stack
// depends on dws_pkg
`default_nettype none
interface dws_req_if;
   import dws_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [2:0]                kind;
   logic signed [VALUE_W-1:0] push_value;
   modport source (output valid, kind, push_value, input ready);
   modport sink   (input valid, kind, push_value, output ready);
endinterface

interface dws_rsp_if;
   import dws_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;
   logic                      last;
   logic [FILL_W-1:0]         fill;
   logic                      can_split;
   logic [1:0]                status;
   modport source (output valid, value, last, fill, can_split, status, input ready);
   modport sink   (input valid, value, last, fill, can_split, status, output ready);
endinterface
`default_nettype wire

>>> sv/dws_ram.sv
// generic single-port-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module dws_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> sv/dws_div.sv
// restoring serial divider, one quotient bit per cycle, 7-bit dividend
// by 8-bit divisor; depends on dws_pkg
`default_nettype none
module dws_div
   import dws_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [FILL_W-1:0] dividend,
   input  wire logic [DIV_W-1:0]  divisor,
   output logic                   busy,
   output logic [FILL_W-1:0]      quotient
);
   logic [FILL_W-1:0] q_ff, q_in;
   logic [DIV_W:0]    r_ff, r_in;
   logic [DIV_W-1:0]  d_ff, d_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [DIV_W:0]    trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {r_ff[DIV_W-1:0], q_ff[FILL_W-1]};
      if (start) begin
         q_in    = dividend;
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = 3'(FILL_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[FILL_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[FILL_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 3'd1;
         if (cnt_ff == 3'd0) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign busy     = busy_ff | start;
   assign quotient = q_ff;
endmodule
`default_nettype wire

>>> sv/dws_ctrl.sv
// controller state machine for the dfs work stack
// depends on dws_pkg
`default_nettype none
module dws_ctrl
   import dws_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire logic    rsp_ready,
   output logic         rsp_valid,
   input  wire sts_type sts,
   output cmd_type      cmd
);
   state_type state_ff, state_in;
   logic      split_ff, split_in;

   always_comb begin
      state_in = state_ff;
      split_in = split_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            split_in = 1'b0;
            state_in = S_TOP_RD;
         end
         S_TOP_RD:   state_in = (sts.kind == KIND_SPLIT) ? S_FIND_RD : S_TOP_WAIT;
         S_TOP_WAIT: state_in = S_CS_START;
         S_CS_START: state_in = S_CS_WAIT;
         S_CS_WAIT:  if (!sts.div_busy) state_in = split_ff ? S_SCAN_RD : S_RESULT;
         S_FIND_RD: begin
            if (!sts.scan_done) state_in = S_FIND_CHK;
            else if (sts.seg_zero) state_in = S_CS_START;
            else state_in = S_N_START;
         end
         S_FIND_CHK: state_in = sts.found ? S_N_START : S_FIND_RD;
         S_N_START:  state_in = S_N_WAIT;
         S_N_WAIT: if (!sts.div_busy) begin
            split_in = 1'b1;
            state_in = S_CS_START;
         end
         S_SCAN_RD:  state_in = sts.scan_done ? S_IDLE : S_SCAN_CHK;
         S_SCAN_CHK: state_in = sts.rem_zero ? S_SCAN_RD : S_EMIT;
         S_EMIT:     if (rsp_ready) state_in = S_SCAN_RD;
         S_RESULT:   if (rsp_ready) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_TOP_RD:   cmd.rd_top = 1'b1;
         S_TOP_WAIT: cmd.do_op = 1'b1;
         S_CS_START: cmd.div_cs = 1'b1;
         S_CS_WAIT:  cmd.cs_load = !sts.div_busy;
         S_FIND_RD: begin
            cmd.rd_scan = !sts.scan_done;
            cmd.fail    = sts.scan_done && sts.seg_zero;
         end
         S_FIND_CHK: cmd.find_step = 1'b1;
         S_N_START:  cmd.div_n = 1'b1;
         S_N_WAIT:   cmd.set_n = !sts.div_busy;
         S_SCAN_RD:  cmd.rd_scan = !sts.scan_done;
         S_SCAN_CHK: cmd.scan_step = 1'b1;
         S_EMIT:     rsp_valid = 1'b1;
         S_RESULT:   rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         split_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         split_ff <= split_in;
      end
   end
endmodule
`default_nettype wire

>>> sv/dws_dp.sv
// datapath for the dfs work stack: entry ram, counters, scan pointers, divider
// depends on dws_pkg, dws_ram and dws_div
`default_nettype none
module dws_dp
   import dws_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write,
   input  wire logic [DIV_W-1:0]          csr_wdata,
   input  wire logic [2:0]                req_kind,
   input  wire logic signed [VALUE_W-1:0] req_push_value,
   input  wire cmd_type                   cmd,
   output sts_type                        sts,
   output logic signed [VALUE_W-1:0]      rsp_value,
   output logic                           rsp_last,
   output logic [FILL_W-1:0]              rsp_fill,
   output logic                           rsp_can_split,
   output logic [1:0]                     rsp_status
);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [DIV_W-1:0]   div_ff;
   logic [FILL_W-1:0]  cnt_ff, cnt_in, opn_ff, opn_in, lim_ff, lim_in;
   logic [2:0]         kind_ff;
   logic [VALUE_W-1:0] pv_ff;
   logic [FILL_W-1:0]  r_ff, r_in, w_ff, w_in, seg_ff, seg_in, rem_ff, rem_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   status_type         stat_ff, stat_in;
   logic               last_ff, last_in;
   logic               cs_ff, cs_in;
   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [VALUE_W-1:0] wr_data, rd_data, neg_v;
   logic               div_start, div_busy;
   logic [FILL_W-1:0]  dividend, quot, floors, n_take;
   logic [DIV_W-1:0]   dsr;

   dws_ram #(.WIDTH(VALUE_W), .DEPTH(STACK_DEPTH)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   dws_div u_div (
      .clock, .reset, .start(div_start), .dividend, .divisor(dsr),
      .busy(div_busy), .quotient(quot)
   );

   assign neg_v     = ~rd_data + VALUE_W'(1);
   assign dsr       = (div_ff == '0) ? DIV_W'(1) : div_ff;
   assign floors    = opn_ff + 7'd1;
   assign n_take    = quot + 7'd1;
   assign div_start = cmd.div_cs | cmd.div_n;

   always_comb begin
      cnt_in   = cnt_ff;
      opn_in   = opn_ff;
      lim_in   = lim_ff;
      r_in     = r_ff;
      w_in     = w_ff;
      seg_in   = seg_ff;
      rem_in   = rem_ff;
      val_in   = val_ff;
      stat_in  = stat_ff;
      last_in  = last_ff;
      cs_in    = cs_ff;
      wr_en    = 1'b0;
      wr_addr  = cnt_ff[AW-1:0];
      wr_data  = pv_ff;
      rd_addr  = r_ff[AW-1:0];
      dividend = '0;
      if (cmd.load) begin
         r_in    = '0;
         w_in    = '0;
         seg_in  = '0;
         rem_in  = '0;
         lim_in  = cnt_ff;
         val_in  = '0;
         stat_in = ST_OK;
         last_in = 1'b1;
      end
      if (cmd.rd_top) rd_addr = AW'(cnt_ff - 7'd1);
      if (cmd.do_op) begin
         case (kind_ff)
            KIND_PUSH: if (cnt_ff >= FILL_W'(STACK_DEPTH)) begin
               stat_in = ST_OVERFLOW;
            end else begin
               wr_en  = 1'b1;
               cnt_in = cnt_ff + 7'd1;
               if (pv_ff[VALUE_W-1]) opn_in = opn_ff + 7'd1;
            end
            KIND_POP: if (cnt_ff == '0) begin
               stat_in = ST_UNDERFLOW;
            end else begin
               cnt_in = cnt_ff - 7'd1;
               val_in = rd_data;
               if (rd_data[VALUE_W-1] && opn_ff != '0) opn_in = opn_ff - 7'd1;
            end
            KIND_OPEN: if (cnt_ff == '0) begin
               stat_in = ST_UNDERFLOW;
            end else begin
               wr_en   = 1'b1;
               wr_addr = AW'(cnt_ff - 7'd1);
               wr_data = neg_v;
               val_in  = neg_v;
               if (rd_data[VALUE_W-1] && !neg_v[VALUE_W-1] && opn_ff != '0)
                  opn_in = opn_ff - 7'd1;
               else if (!rd_data[VALUE_W-1] && neg_v[VALUE_W-1])
                  opn_in = opn_ff + 7'd1;
            end
            KIND_PEEK: if (cnt_ff == '0) stat_in = ST_UNDERFLOW;
               else val_in = rd_data;
            default: ;
         endcase
      end
      if (cmd.rd_scan) begin
         rd_addr = r_ff[AW-1:0];
         r_in    = r_ff + 7'd1;
      end
      // lowest floor holding unopened entries
      if (cmd.find_step && !rd_data[VALUE_W-1]) seg_in = seg_ff + 7'd1;
      if (cmd.fail) stat_in = ST_NOSPLIT;
      // share size is ceil(seg / divider) = (seg - 1) / divider + 1
      if (cmd.div_n) dividend = seg_ff - 7'd1;
      if (cmd.set_n) begin
         rem_in = n_take;
         cnt_in = cnt_ff - n_take;
         r_in   = '0;
         w_in   = '0;
      end
      if (cmd.div_cs) dividend = (cnt_ff < floors) ? '0 : cnt_ff - floors;
      if (cmd.cs_load) cs_in = quot > 7'd1;
      if (cmd.scan_step) begin
         if (rem_ff != '0) begin
            val_in  = rd_data;
            last_in = 1'b0;
            if (rd_data[VALUE_W-1]) begin
               wr_en   = 1'b1;
               wr_addr = w_ff[AW-1:0];
               wr_data = rd_data;
               w_in    = w_ff + 7'd1;
            end else begin
               rem_in  = rem_ff - 7'd1;
               last_in = rem_ff == 7'd1;
            end
         end else begin
            wr_en   = 1'b1;
            wr_addr = w_ff[AW-1:0];
            wr_data = rd_data;
            w_in    = w_ff + 7'd1;
         end
      end
   end

   always_comb begin
      sts.kind      = kind_ff;
      sts.scan_done = r_ff >= lim_ff;
      sts.seg_zero  = seg_ff == '0;
      sts.found     = rd_data[VALUE_W-1] && seg_ff != '0;
      sts.rem_zero  = rem_ff == '0;
      sts.div_busy  = div_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff  <= DIV_W'(2);
         cnt_ff  <= '0;
         opn_ff  <= '0;
         lim_ff  <= '0;
         kind_ff <= '0;
         pv_ff   <= '0;
         r_ff    <= '0;
         w_ff    <= '0;
         seg_ff  <= '0;
         rem_ff  <= '0;
         val_ff  <= '0;
         stat_ff <= ST_OK;
         last_ff <= 1'b0;
         cs_ff   <= 1'b0;
      end else begin
         if (csr_write) div_ff <= csr_wdata;
         if (cmd.load) begin
            kind_ff <= req_kind;
            pv_ff   <= req_push_value;
         end
         cnt_ff  <= cnt_in;
         opn_ff  <= opn_in;
         lim_ff  <= lim_in;
         r_ff    <= r_in;
         w_ff    <= w_in;
         seg_ff  <= seg_in;
         rem_ff  <= rem_in;
         val_ff  <= val_in;
         stat_ff <= stat_in;
         last_ff <= last_in;
         cs_ff   <= cs_in;
      end
   end

   assign rsp_value     = $signed(val_ff);
   assign rsp_last      = last_ff;
   assign rsp_fill      = cnt_ff;
   assign rsp_can_split = cs_ff;
   assign rsp_status    = stat_ff;
endmodule
`default_nettype wire

>>> sv/dfs_work_stack_with_split.sv
// dfs work stack with work splitting, top level
// push, pop, open, peek: one request at a time; the op is followed by a serial divide
// for can_split, and the result is then held until rsp.ready
// split: search the entries for the lowest floor, divide for the share size, divide
// for can_split, then scan the entries, emitting each one until the share is taken
// synchronous active-high reset empties the stack and sets the divider to 2
`default_nettype none
module dfs_work_stack_with_split
   import dws_pkg::*;
#(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write,
   input  wire logic [DIV_W-1:0] csr_wdata,
   dws_req_if.sink               req,
   dws_rsp_if.source             rsp
);
   cmd_type cmd;
   sts_type sts;

   dws_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_ready(rsp.ready), .rsp_valid(rsp.valid),
      .sts, .cmd
   );

   dws_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock, .reset, .csr_write, .csr_wdata,
      .req_kind(req.kind), .req_push_value(req.push_value),
      .cmd, .sts,
      .rsp_value(rsp.value), .rsp_last(rsp.last), .rsp_fill(rsp.fill),
      .rsp_can_split(rsp.can_split), .rsp_status(rsp.status)
   );
endmodule
`default_nettype wire
